>>> rtl/adsr_pkg.sv
// Shared types, codes and the rate selection function of the envelope generator.
`timescale 1ns / 1ps

package adsr_pkg;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_KEY_ON  = 3'd1;
    localparam logic [2:0] CMD_KEY_OFF = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_WRITE   = 3'd4;

    localparam logic [2:0] PH_ATTACK  = 3'd0;
    localparam logic [2:0] PH_DECAY   = 3'd1;
    localparam logic [2:0] PH_SUSTAIN = 3'd2;
    localparam logic [2:0] PH_RELEASE = 3'd3;
    localparam logic [2:0] PH_STOPPED = 3'd4;

    localparam logic [15:0] LEVEL_MAX  = 16'h7fff;
    localparam logic [15:0] EXP_KNEE   = 16'h6000;
    localparam logic [15:0] CINC_BASE  = 16'h8000;
    localparam logic [4:0]  SHIFT_KNEE = 5'd11;
    localparam logic [4:0]  SHIFT_MID  = 5'd10;
    localparam logic [6:0]  RATE_INF   = 7'h7f;
    localparam logic signed [3:0] STEP_FALL = 4'b1000;

    typedef struct packed {
        logic              decr;
        logic              expo;
        logic [4:0]        shift;
        logic signed [3:0] step;
        logic [15:0]       target;
        logic              infinite;
    } rate_t;

    typedef struct packed {
        logic [14:0] level;
        logic [2:0]  phase;
        logic [15:0] counter;
        rate_t       rate;
        logic [15:0] ad;
        logic [15:0] sr;
        logic        running;
    } voice_state_t;

    function automatic rate_t cache_rate(input logic [2:0] phase, input logic [15:0] ad,
                                         input logic [15:0] sr, input rate_t old);
        rate_t r;
        r = old;
        unique case (phase)
            PH_ATTACK:
            begin
                r.decr     = 1'b0;
                r.expo     = ad[15];
                r.shift    = ad[14:10];
                r.step     = $signed(4'd7 - {2'b00, ad[9:8]});
                r.target   = LEVEL_MAX;
                r.infinite = (ad[14:8] == RATE_INF);
            end
            PH_DECAY:
            begin
                r.decr     = 1'b1;
                r.expo     = 1'b1;
                r.shift    = {1'b0, ad[7:4]};
                r.step     = STEP_FALL;
                r.target   = {({1'b0, ad[3:0]} + 5'd1), 11'd0};
                r.infinite = (ad[7:4] == 4'hf);
            end
            PH_SUSTAIN:
            begin
                r.decr     = sr[14];
                r.expo     = sr[15];
                r.shift    = sr[12:8];
                r.step     = sr[14] ? $signed({2'b00, sr[7:6]} - 4'd8)
                                    : $signed(4'd7 - {2'b00, sr[7:6]});
                r.target   = 16'd0;
                r.infinite = (sr[12:6] == RATE_INF);
            end
            PH_RELEASE:
            begin
                r.decr     = 1'b1;
                r.expo     = sr[5];
                r.shift    = sr[4:0];
                r.step     = STEP_FALL;
                r.target   = 16'd0;
                r.infinite = (sr[4:0] == 5'h1f);
            end
            default:
            begin
                r = old;
            end
        endcase
        return r;
    endfunction

endpackage

>>> rtl/adsr_voice_ram.sv
// Per-voice state store: synchronous memory with registered read and per-entry valid flags.
`timescale 1ns / 1ps

module adsr_voice_ram
    import adsr_pkg::*;
#(
    parameter int VOICES = 48,
    parameter int IDX_W  = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output voice_state_t       rd_data,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  voice_state_t       wr_data
);

    voice_state_t      mem_reg [VOICES];
    voice_state_t      rd_data_reg;
    logic [VOICES-1:0] valid_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    // An entry that has never been written reads as the cleared state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> rtl/adsr_step_unit.sv
// Envelope step datapath: rate and multiply stage, then level update and command handling.
`timescale 1ns / 1ps

module adsr_step_unit
    import adsr_pkg::*;
(
    input  logic         clk,
    input  logic         load,
    input  voice_state_t cur,
    input  logic [2:0]   cmd,
    input  logic [15:0]  ad_word,
    input  logic [15:0]  sr_word,
    output voice_state_t nxt
);

    logic [4:0]         sh;
    logic [3:0]         k;
    logic [15:0]        cinc;
    logic signed [15:0] linc_raw;
    logic signed [15:0] linc;
    logic               knee;
    logic               use_mult;
    logic [15:0]        cnt_sum;
    logic signed [31:0] product;

    logic [15:0]        cnt_sum_reg;
    logic signed [15:0] linc_reg;
    logic signed [31:0] prod_reg;
    logic               use_mult_reg;

    logic signed [15:0] step_lvl;
    logic signed [16:0] lvl_sum;
    logic [14:0]        lvl_clamped;
    logic [14:0]        lvl_new;
    logic               overflow;
    logic               reach;
    voice_state_t       t;
    voice_state_t       rest;

    always_comb
    begin
        sh       = cur.rate.shift;
        k        = (sh < SHIFT_KNEE) ? 4'(SHIFT_KNEE - sh) : 4'd0;
        cinc     = (sh > SHIFT_KNEE) ? (CINC_BASE >> (sh - SHIFT_KNEE)) : CINC_BASE;
        linc_raw = $signed({{12{cur.rate.step[3]}}, cur.rate.step}) <<< k;
        linc     = linc_raw;
        knee     = cur.rate.expo && !cur.rate.decr && ({1'b0, cur.level} >= EXP_KNEE);
        use_mult = cur.rate.expo && cur.rate.decr;
        if (knee)
        begin
            priority if (sh < SHIFT_MID)
            begin
                linc = linc_raw >>> 2;
            end
            else if (sh >= SHIFT_KNEE)
            begin
                cinc = cinc >> 2;
            end
            else
            begin
                cinc = cinc >> 1;
                linc = linc_raw >>> 1;
            end
        end
        if (!cur.rate.infinite && (cinc == 16'd0))
        begin
            cinc = 16'd1;
        end
        cnt_sum = cur.counter + cinc;
        product = linc_raw * $signed({1'b0, cur.level});
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cnt_sum_reg  <= cnt_sum;
            linc_reg     <= linc;
            prod_reg     <= product;
            use_mult_reg <= use_mult;
        end
    end

    // The product shifted right by 15 with sign rounds toward minus infinity.
    always_comb
    begin
        step_lvl    = use_mult_reg ? prod_reg[30:15] : linc_reg;
        overflow    = cnt_sum_reg[15];
        lvl_sum     = $signed({2'b00, cur.level}) + $signed({step_lvl[15], step_lvl});
        priority if (lvl_sum < 17'sd0)
        begin
            lvl_clamped = 15'd0;
        end
        else if (lvl_sum > $signed({1'b0, LEVEL_MAX}))
        begin
            lvl_clamped = LEVEL_MAX[14:0];
        end
        else
        begin
            lvl_clamped = lvl_sum[14:0];
        end
        lvl_new = overflow ? lvl_clamped : cur.level;
        reach   = cur.rate.decr ? ({1'b0, lvl_new} <= cur.rate.target)
                                : ({1'b0, lvl_new} >= cur.rate.target);

        t = cur;
        if (cur.phase > PH_RELEASE)
        begin
            t.running = 1'b0;
        end
        else
        begin
            t.counter = overflow ? 16'd0 : cnt_sum_reg;
            t.level   = lvl_new;
            if ((cur.phase != PH_SUSTAIN) && reach)
            begin
                t.phase = cur.phase + 3'd1;
                t.rate  = cache_rate(t.phase, cur.ad, cur.sr, cur.rate);
                if (t.phase == PH_STOPPED)
                begin
                    t.running = 1'b0;
                end
            end
        end

        rest = cur;
        unique case (cmd)
            CMD_TICK:
            begin
                if (cur.running)
                begin
                    rest = t;
                end
            end
            CMD_KEY_ON:
            begin
                rest.running = 1'b1;
                rest.level   = 15'd0;
                rest.counter = 16'd0;
                rest.phase   = PH_ATTACK;
                rest.rate    = cache_rate(PH_ATTACK, cur.ad, cur.sr, cur.rate);
            end
            CMD_KEY_OFF:
            begin
                if (cur.phase < PH_RELEASE)
                begin
                    rest.phase = PH_RELEASE;
                    rest.rate  = cache_rate(PH_RELEASE, cur.ad, cur.sr, cur.rate);
                end
            end
            CMD_STOP:
            begin
                rest.level   = 15'd0;
                rest.phase   = PH_STOPPED;
                rest.running = 1'b0;
            end
            CMD_WRITE:
            begin
                rest.ad = ad_word;
                rest.sr = sr_word;
            end
            default:
            begin
                rest = cur;
            end
        endcase
        nxt = rest;
    end

endmodule

>>> rtl/adsr_envelope_generator.sv
// Top level of the multi-voice envelope generator: command sequencer, state store and results.
//
//   Channel   Direction  Handshake            Contents
//   command   in         start && !busy       command, voice, attack_decay_word,
//                                             sustain_release_word
//   result    out        done, one cycle      voice_out, level, phase_out, active, finished
//
// Each word passes from acceptance to the done strobe through the synchronous read of the
// voice store, the step multiplier and the update and write back.
// A new word is accepted only once the last one is through; busy is high meanwhile.
// After reset every voice reads as cleared through per-voice valid flags; no clearing pass.
// The receiver cannot stall, so a result is shown for exactly the cycle after its write back.
`timescale 1ns / 1ps

module adsr_envelope_generator
    import adsr_pkg::*;
#(
    parameter int VOICES = 48
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [5:0]  voice,
    input  logic [15:0] attack_decay_word,
    input  logic [15:0] sustain_release_word,
    output logic        done,
    output logic [5:0]  voice_out,
    output logic [14:0] level,
    output logic [2:0]  phase_out,
    output logic        active,
    output logic        finished
);

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]   state_reg;
    logic [1:0]   state_next;
    logic [2:0]   cmd_reg;
    logic [5:0]   voice_reg;
    logic [15:0]  adw_reg;
    logic [15:0]  srw_reg;
    logic         in_range_reg;
    logic         accept;
    logic         in_range;
    voice_state_t rd_data;
    voice_state_t nxt;
    logic         wr_en;

    logic         done_reg;
    logic [5:0]   voice_out_reg;
    logic [14:0]  level_reg;
    logic [2:0]   phase_reg;
    logic         active_reg;
    logic         finished_reg;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = ({1'b0, voice} < 7'(VOICES));
    assign wr_en    = (state_reg == ST_DONE) && in_range_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: state_next = accept ? ST_CALC : ST_IDLE;
            ST_CALC: state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= command;
            voice_reg    <= voice;
            adw_reg      <= attack_decay_word;
            srw_reg      <= sustain_release_word;
            in_range_reg <= in_range;
        end
        if (state_reg == ST_DONE)
        begin
            voice_out_reg <= voice_reg;
            if (in_range_reg)
            begin
                level_reg    <= nxt.level;
                phase_reg    <= nxt.phase;
                active_reg   <= nxt.running;
                finished_reg <= (nxt.level == 15'd0) && (nxt.phase != PH_ATTACK);
            end
            else
            begin
                level_reg    <= 15'd0;
                phase_reg    <= PH_STOPPED;
                active_reg   <= 1'b0;
                finished_reg <= 1'b1;
            end
        end
    end

    adsr_voice_ram #(
        .VOICES (VOICES),
        .IDX_W  (IDX_W)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && in_range),
        .rd_addr (voice[IDX_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (voice_reg[IDX_W-1:0]),
        .wr_data (nxt)
    );

    adsr_step_unit u_step (
        .clk     (clk),
        .load    (state_reg == ST_CALC),
        .cur     (rd_data),
        .cmd     (cmd_reg),
        .ad_word (adw_reg),
        .sr_word (srw_reg),
        .nxt     (nxt)
    );

    assign done      = done_reg;
    assign voice_out = voice_out_reg;
    assign level     = level_reg;
    assign phase_out = phase_reg;
    assign active    = active_reg;
    assign finished  = finished_reg;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##2 done)
        else $error("accepted word did not produce a result three cycles later");

    a_word_held: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && $past(busy)) |-> ($stable(voice_reg) && $stable(cmd_reg)))
        else $error("held command word changed while the voice was in flight");

    a_active_not_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (done && active) |-> (phase_out != PH_STOPPED))
        else $error("running voice reported in the stopped phase");

endmodule
